>>> rtl/avfe_pkg.sv
// Package for the analytic vector field evaluator.
// Holds register indexes, pattern codes, CORDIC constants and small helper functions.
// No dependencies.
package avfe_pkg;

	localparam int unsigned NUM_STAGES = 99;

	typedef enum logic [2:0] {
		CFG_PATTERN_MODE = 3'd0,
		CFG_TRANSLATE_EN = 3'd1,
		CFG_ROTATE_EN    = 3'd2,
		CFG_ROTATE_RATE  = 3'd3,
		CFG_MAX_MAG      = 3'd4,
		CFG_UNIFORM_X    = 3'd5,
		CFG_UNIFORM_Y    = 3'd6
	} cfg_index_t;

	typedef enum logic [2:0] {
		MODE_UNIFORM     = 3'd0,
		MODE_CENTRIPETAL = 3'd1,
		MODE_SWIRL       = 3'd2,
		MODE_SWIRL_Y     = 3'd3,
		MODE_SWIRL_X     = 3'd4,
		MODE_HYPERBOLIC  = 3'd5
	} mode_t;

	localparam logic [29:0] MAGIC_DIV9    = 30'd954437177;
	localparam logic [32:0] MAGIC_DIV45   = 33'd6108397933;
	localparam logic [31:0] TURN_PER_360  = 32'd11930464;
	localparam logic [31:0] ELL_STEP      = 32'd3640;
	localparam logic [30:0] DIV45_OFFSET  = 31'd5760;
	localparam logic [31:0] DIV45_BIAS    = 32'd128;
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
	localparam logic signed [30:0] HALF_SQRT2 = 31'sd759250125;
	localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

	function automatic logic [29:0] cordic_atan(input int unsigned idx);
		logic [29:0] r;
		case (idx)
			0:  r = 30'd536870912;
			1:  r = 30'd316933406;
			2:  r = 30'd167458907;
			3:  r = 30'd85004756;
			4:  r = 30'd42667331;
			5:  r = 30'd21354465;
			6:  r = 30'd10679838;
			7:  r = 30'd5340245;
			8:  r = 30'd2670163;
			9:  r = 30'd1335087;
			10: r = 30'd667544;
			11: r = 30'd333772;
			12: r = 30'd166886;
			13: r = 30'd83443;
			14: r = 30'd41722;
			15: r = 30'd20861;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// floor(8 * r / 9) for a remainder of a division by nine.
	function automatic logic [2:0] frac8_9(input logic [3:0] r);
		logic [2:0] f;
		case (r)
			4'd0, 4'd1: f = 3'd0;
			4'd2: f = 3'd1;
			4'd3: f = 3'd2;
			4'd4: f = 3'd3;
			4'd5: f = 3'd4;
			4'd6: f = 3'd5;
			4'd7: f = 3'd6;
			4'd8: f = 3'd7;
			default: f = 3'd0;
		endcase
		return f;
	endfunction

	function automatic logic signed [31:0] clamp_unit(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sd1073741824) begin
			r = ONE_Q30;
		end else if (v < -33'sd1073741824) begin
			r = -ONE_Q30;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/analytic_vector_field_eval_unit.sv
// Top level of the analytic vector field evaluator: a 99-stage pipeline.
// Depends on avfe_pkg; checked by avfe_checker.
//
// Usage: the input channel (in_valid, in_stall) carries one word of point_x,
// point_y and time_s; the output channel (out_valid, out_stall) returns one
// word of vel_x, vel_y for each input word, in order.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata while
// no word is in flight.
// out_valid rises when an accepted word reaches the 99th register stage; one word is
// accepted in every cycle in which the pipeline does not hold. The length is
// set by the two 16-step CORDIC units, the 32-step square root and the 31-step
// quotient, each one step per stage.
// Reset clears all valid bits, loads the register defaults and puts the
// swirl centre at the origin.
// When the receiver stalls a held result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is lost or repeated.
module analytic_vector_field_eval_unit
	import avfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic        [31:0] time_s,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	input  logic               cfg_wr_en,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_wdata
);

	logic [2:0] mode_q;
	logic translate_q;
	logic rotate_q;
	logic signed [31:0] rate_q;
	logic [30:0] max_q;
	logic signed [31:0] unif_x_q;
	logic signed [31:0] unif_y_q;
	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;

	logic vld_s [1:NUM_STAGES];
	logic adv;

	assign adv = !(vld_s[NUM_STAGES] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_s[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UNIFORM;
			translate_q <= 1'b0;
			rotate_q <= 1'b0;
			rate_q <= '0;
			max_q <= 31'h7FFFFFFF;
			unif_x_q <= '0;
			unif_y_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_PATTERN_MODE: mode_q <= cfg_wdata[2:0];
				CFG_TRANSLATE_EN: translate_q <= cfg_wdata[0];
				CFG_ROTATE_EN:    rotate_q <= cfg_wdata[0];
				CFG_ROTATE_RATE:  rate_q <= cfg_wdata;
				CFG_MAX_MAG:      max_q <= cfg_wdata[30:0];
				CFG_UNIFORM_X:    unif_x_q <= cfg_wdata;
				CFG_UNIFORM_Y:    unif_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NUM_STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= NUM_STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Point coordinates ride along until the offset stage.
	logic signed [31:0] px_d [1:27];
	logic signed [31:0] py_d [1:27];
	logic [31:0] t_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_d[1] <= point_x;
			py_d[1] <= point_y;
			t_s1 <= time_s;
			for (int i = 2; i <= 27; i++) begin
				px_d[i] <= px_d[i-1];
				py_d[i] <= py_d[i-1];
			end
		end
	end

	// Phase generation for the ellipse and for the vector rotation.
	logic signed [63:0] rprod_s2;
	logic [61:0] emul_s2;
	logic [31:0] t_s2;
	logic [31:0] ph_e_s3, ph_e_s4, ph_e_s5, ph_e_s6;
	logic [40:0] w_s3;
	logic [31:0] base1_s3;
	logic [33:0] v_s4;
	logic [31:0] base2_s4, base2_s5;
	logic [63:0] divp_s5;
	logic [31:0] ph_r_s6;

	logic [28:0] q9;
	logic [31:0] r9;
	logic [8:0] wh;
	logic [30:0] x45;

	always_comb begin
		q9 = emul_s2[61:33];
		r9 = t_s2 - 32'({q9, 3'b000} + {3'b000, q9});
		wh = w_s3[40:32];
		x45 = v_s4[33:3] + DIV45_OFFSET;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rprod_s2 <= rate_q * $signed({1'b0, t_s1});
			emul_s2 <= 62'(t_s1) * 62'(MAGIC_DIV9);
			t_s2 <= t_s1;
			ph_e_s3 <= 32'(t_s2 * ELL_STEP) + {q9, 3'b000} + {29'd0, frac8_9(r9[3:0])};
			w_s3 <= {rprod_s2[63], rprod_s2[63:32], 8'h00} + {9'd0, rprod_s2[31:0]};
			base1_s3 <= 32'(rprod_s2[63:32] * TURN_PER_360);
			ph_e_s4 <= ph_e_s3;
			v_s4 <= {{17{wh[8]}}, wh, 8'h00} + {2'b00, w_s3[31:0]};
			base2_s4 <= base1_s3 + 32'({{23{wh[8]}}, wh} * TURN_PER_360);
			ph_e_s5 <= ph_e_s4;
			base2_s5 <= base2_s4;
			divp_s5 <= 64'(x45) * 64'(MAGIC_DIV45);
			ph_e_s6 <= ph_e_s5;
			ph_r_s6 <= base2_s5 + {6'd0, divp_s5[63:38]} - DIV45_BIAS;
		end
	end

	// Two CORDIC lanes: lane 0 for the ellipse, lane 1 for the rotation.
	logic signed [32:0] cor_x_s [17][2];
	logic signed [32:0] cor_y_s [17][2];
	logic signed [32:0] cor_z_s [17][2];
	logic [1:0] cor_q_s [17][2];
	logic [31:0] ph_in [2];
	logic [1:0] quad_in [2];
	logic [31:0] zin [2];

	always_comb begin
		ph_in[0] = ph_e_s6;
		ph_in[1] = ph_r_s6;
		for (int l = 0; l < 2; l++) begin
			quad_in[l] = 2'((ph_in[l] + 32'h2000_0000) >> 30);
			zin[l] = ph_in[l] - {quad_in[l], 30'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				cor_x_s[0][l] <= CORDIC_X0;
				cor_y_s[0][l] <= '0;
				cor_z_s[0][l] <= {zin[l][31], zin[l]};
				cor_q_s[0][l] <= quad_in[l];
			end
		end
	end

	for (genvar j = 1; j <= 16; j++) begin : g_cor
		for (genvar l = 0; l < 2; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) begin
					cor_q_s[j][l] <= cor_q_s[j-1][l];
					if (!cor_z_s[j-1][l][32]) begin
						cor_x_s[j][l] <= cor_x_s[j-1][l] - (cor_y_s[j-1][l] >>> (j-1));
						cor_y_s[j][l] <= cor_y_s[j-1][l] + (cor_x_s[j-1][l] >>> (j-1));
						cor_z_s[j][l] <= cor_z_s[j-1][l] - $signed({3'b000, cordic_atan(j-1)});
					end else begin
						cor_x_s[j][l] <= cor_x_s[j-1][l] + (cor_y_s[j-1][l] >>> (j-1));
						cor_y_s[j][l] <= cor_y_s[j-1][l] - (cor_x_s[j-1][l] >>> (j-1));
						cor_z_s[j][l] <= cor_z_s[j-1][l] + $signed({3'b000, cordic_atan(j-1)});
					end
				end
			end
		end
	end

	logic signed [31:0] cos_d [24:28][2];
	logic signed [31:0] sin_d [24:28][2];
	logic signed [31:0] cl_x [2];
	logic signed [31:0] cl_y [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			cl_x[l] = clamp_unit(cor_x_s[16][l]);
			cl_y[l] = clamp_unit(cor_y_s[16][l]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				case (cor_q_s[16][l])
					2'd0: begin
						cos_d[24][l] <= cl_x[l];
						sin_d[24][l] <= cl_y[l];
					end
					2'd1: begin
						cos_d[24][l] <= -cl_y[l];
						sin_d[24][l] <= cl_x[l];
					end
					2'd2: begin
						cos_d[24][l] <= -cl_x[l];
						sin_d[24][l] <= -cl_y[l];
					end
					default: begin
						cos_d[24][l] <= cl_y[l];
						sin_d[24][l] <= -cl_x[l];
					end
				endcase
				for (int i = 25; i <= 28; i++) begin
					cos_d[i][l] <= cos_d[i-1][l];
					sin_d[i][l] <= sin_d[i-1][l];
				end
			end
		end
	end

	// Swirl centre on the rotated ellipse.
	logic signed [36:0] e20, e5;
	logic signed [22:0] ex_s25, ey_s25;
	logic signed [55:0] mx_s26, my_s26;
	logic signed [55:0] mxr, myr;
	logic signed [31:0] cxn, cyn;
	logic signed [31:0] cx_s27, cy_s27;

	always_comb begin
		e20 = 37'(cos_d[24][0]) * 37'sd20 + 37'sd8192;
		e5 = 37'(sin_d[24][0]) * 37'sd5 + 37'sd8192;
		mxr = mx_s26 + 56'sd536870912;
		myr = my_s26 + 56'sd536870912;
		cxn = 32'($signed(mxr[55:30]));
		cyn = 32'($signed(myr[55:30]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s25 <= e20[36:14];
			ey_s25 <= e5[36:14];
			mx_s26 <= 56'(24'(ex_s25) - 24'(ey_s25)) * 56'(HALF_SQRT2);
			my_s26 <= 56'(24'(ex_s25) + 24'(ey_s25)) * 56'(HALF_SQRT2);
			cx_s27 <= translate_q ? cxn : center_x_q;
			cy_s27 <= translate_q ? cyn : center_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
		end else if (adv && vld_s[26] && translate_q) begin
			center_x_q <= cxn;
			center_y_q <= cyn;
		end
	end

	// Pattern and rotation.
	logic signed [33:0] dx, dy;
	logic signed [33:0] vx_s28, vy_s28, vx_s29, vy_s29;
	logic signed [65:0] pxc_s29, pys_s29, pxs_s29, pyc_s29;
	logic signed [66:0] rxw, ryw;
	logic signed [35:0] vx_s30, vy_s30;

	always_comb begin
		dx = 34'(px_d[27]) - 34'(cx_s27);
		dy = 34'(py_d[27]) - 34'(cy_s27);
		rxw = 67'(pxc_s29) - 67'(pys_s29) + 67'sd536870912;
		ryw = 67'(pxs_s29) + 67'(pyc_s29) + 67'sd536870912;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (mode_q)
				MODE_UNIFORM: begin
					vx_s28 <= 34'(unif_x_q);
					vy_s28 <= 34'(unif_y_q);
				end
				MODE_CENTRIPETAL: begin
					vx_s28 <= -dx;
					vy_s28 <= -dy;
				end
				MODE_SWIRL: begin
					vx_s28 <= dy - dx;
					vy_s28 <= -dx - dy;
				end
				MODE_SWIRL_Y: begin
					vx_s28 <= dy;
					vy_s28 <= dy - dx;
				end
				MODE_SWIRL_X: begin
					vx_s28 <= -dx;
					vy_s28 <= -dx - dy;
				end
				MODE_HYPERBOLIC: begin
					vx_s28 <= dx;
					vy_s28 <= dx - dy;
				end
				default: begin
					vx_s28 <= '0;
					vy_s28 <= '0;
				end
			endcase
			vx_s29 <= vx_s28;
			vy_s29 <= vy_s28;
			pxc_s29 <= 66'(vx_s28) * 66'(cos_d[28][1]);
			pys_s29 <= 66'(vy_s28) * 66'(sin_d[28][1]);
			pxs_s29 <= 66'(vx_s28) * 66'(sin_d[28][1]);
			pyc_s29 <= 66'(vy_s28) * 66'(cos_d[28][1]);
			vx_s30 <= rotate_q ? rxw[65:30] : 36'(vx_s29);
			vy_s30 <= rotate_q ? ryw[65:30] : 36'(vy_s29);
		end
	end

	// Norm limit: magnitudes, square root, quotient.
	logic [35:0] a_s31, b_s31;
	logic [30:0] ash_d [32:66];
	logic [30:0] bsh_d [32:66];
	logic neg_x_d [31:98];
	logic neg_y_d [31:98];
	logic signed [31:0] pass_x_d [31:98];
	logic signed [31:0] pass_y_d [31:98];
	logic kpos_s32;
	logic lim_d [33:98];
	logic [61:0] sa_s33, sb_s33, mm_s33;
	logic [35:0] ab_or;
	logic [30:0] ash, bsh;
	logic kpos;

	always_comb begin
		ab_or = a_s31 | b_s31;
		kpos = |ab_or[35:31];
		if (ab_or[35]) begin
			ash = 31'(a_s31 >> 5);
			bsh = 31'(b_s31 >> 5);
		end else if (ab_or[34]) begin
			ash = 31'(a_s31 >> 4);
			bsh = 31'(b_s31 >> 4);
		end else if (ab_or[33]) begin
			ash = 31'(a_s31 >> 3);
			bsh = 31'(b_s31 >> 3);
		end else if (ab_or[32]) begin
			ash = 31'(a_s31 >> 2);
			bsh = 31'(b_s31 >> 2);
		end else if (ab_or[31]) begin
			ash = 31'(a_s31 >> 1);
			bsh = 31'(b_s31 >> 1);
		end else begin
			ash = a_s31[30:0];
			bsh = b_s31[30:0];
		end
	end

	logic [62:0] sq_v_s [33];
	logic [63:0] sq_r_s [33];

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s31 <= vx_s30[35] ? 36'(-vx_s30) : 36'(vx_s30);
			b_s31 <= vy_s30[35] ? 36'(-vy_s30) : 36'(vy_s30);
			neg_x_d[31] <= vx_s30[35];
			neg_y_d[31] <= vy_s30[35];
			pass_x_d[31] <= sat32(vx_s30);
			pass_y_d[31] <= sat32(vy_s30);
			for (int i = 32; i <= 98; i++) begin
				neg_x_d[i] <= neg_x_d[i-1];
				neg_y_d[i] <= neg_y_d[i-1];
				pass_x_d[i] <= pass_x_d[i-1];
				pass_y_d[i] <= pass_y_d[i-1];
			end
			ash_d[32] <= ash;
			bsh_d[32] <= bsh;
			for (int i = 33; i <= 66; i++) begin
				ash_d[i] <= ash_d[i-1];
				bsh_d[i] <= bsh_d[i-1];
			end
			kpos_s32 <= kpos;
			lim_d[33] <= kpos_s32;
			sa_s33 <= 62'(ash_d[32]) * 62'(ash_d[32]);
			sb_s33 <= 62'(bsh_d[32]) * 62'(bsh_d[32]);
			mm_s33 <= 62'(max_q) * 62'(max_q);
			lim_d[34] <= lim_d[33] || ((63'(sa_s33) + 63'(sb_s33)) > 63'(mm_s33));
			for (int i = 35; i <= 98; i++) begin
				lim_d[i] <= lim_d[i-1];
			end
			sq_v_s[0] <= 63'(sa_s33) + 63'(sb_s33);
			sq_r_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= 32; j++) begin : g_sqrt
		logic [63:0] trial;
		assign trial = sq_r_s[j-1] + (64'd1 << (62 - 2 * (j - 1)));
		always_ff @(posedge clk) begin
			if (adv) begin
				if ({1'b0, sq_v_s[j-1]} >= trial) begin
					sq_v_s[j] <= sq_v_s[j-1] - trial[62:0];
					sq_r_s[j] <= (sq_r_s[j-1] >> 1) + (64'd1 << (62 - 2 * (j - 1)));
				end else begin
					sq_v_s[j] <= sq_v_s[j-1];
					sq_r_s[j] <= sq_r_s[j-1] >> 1;
				end
			end
		end
	end

	logic [61:0] rem_s [32][2];
	logic [30:0] quo_s [32][2];
	logic [31:0] nrm_s [32];
	logic nz_s [32];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0][0] <= 62'(ash_d[66]) * 62'(max_q);
			rem_s[0][1] <= 62'(bsh_d[66]) * 62'(max_q);
			quo_s[0][0] <= '0;
			quo_s[0][1] <= '0;
			nrm_s[0] <= sq_r_s[32][31:0];
			nz_s[0] <= |sq_r_s[32][31:0];
		end
	end

	for (genvar j = 1; j <= 31; j++) begin : g_div
		logic [62:0] dvs;
		assign dvs = {31'd0, nrm_s[j-1]} << (31 - j);
		always_ff @(posedge clk) begin
			if (adv) begin
				nrm_s[j] <= nrm_s[j-1];
				nz_s[j] <= nz_s[j-1];
			end
		end
		for (genvar l = 0; l < 2; l++) begin : g_lane
			always_ff @(posedge clk) begin
				if (adv) begin
					if ({1'b0, rem_s[j-1][l]} >= dvs) begin
						rem_s[j][l] <= rem_s[j-1][l] - dvs[61:0];
						quo_s[j][l] <= quo_s[j-1][l] | (31'd1 << (31 - j));
					end else begin
						rem_s[j][l] <= rem_s[j-1][l];
						quo_s[j][l] <= quo_s[j-1][l];
					end
				end
			end
		end
	end

	logic use_lim;
	logic signed [31:0] qx, qy;

	always_comb begin
		use_lim = (mode_q != MODE_UNIFORM) && lim_d[98];
		if (!nz_s[31]) begin
			qx = '0;
			qy = '0;
		end else begin
			qx = neg_x_d[98] ? -$signed({1'b0, quo_s[31][0]}) : $signed({1'b0, quo_s[31][0]});
			qy = neg_y_d[98] ? -$signed({1'b0, quo_s[31][1]}) : $signed({1'b0, quo_s[31][1]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vel_x <= use_lim ? qx : pass_x_d[98];
			vel_y <= use_lim ? qy : pass_y_d[98];
		end
	end

endmodule

>>> rtl/avfe_checker.sv
// Port-level checker for the analytic vector field evaluator, bound to the top level.
// Depends on analytic_vector_field_eval_unit.
module avfe_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] vel_y
);

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vel_x) && $stable(vel_y))
		else $error("held output word changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output word");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output word valid straight after reset");

endmodule

bind analytic_vector_field_eval_unit avfe_checker u_avfe_checker (.*);

>>> bench/tb.sv
// Self-checking testbench for analytic_vector_field_eval_unit.
// Predicts each disturbance vector with its own fixed-point model and checks results in order.
// Depends on avfe_pkg and the RTL of the block.
module tb;
	import avfe_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 99;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic        [31:0] time_s = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic               cfg_wr_en = 1'b0;
	logic        [2:0]  cfg_index = '0;
	logic        [31:0] cfg_wdata = '0;

	analytic_vector_field_eval_unit dut (.*);

	always #2 clk = ~clk;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} vec_t;

	vec_t pending_vectors[$];
	int mismatches = 0;
	bit idle_on = 1'b1;
	bit hold_receiver = 1'b0;

	// Predictor state.
	logic [2:0]         m_pattern;
	bit                 m_translate;
	bit                 m_rotate;
	longint             m_rate;
	longint             m_max;
	longint             m_ux;
	longint             m_uy;
	longint             m_cx;
	longint             m_cy;

	localparam longint ATAN_TURN[16] = '{536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};

	function automatic longint clamp_q30(longint v);
		if (v > 64'sd1073741824)
			return 64'sd1073741824;
		if (v < -64'sd1073741824)
			return -64'sd1073741824;
		return v;
	endfunction

	function automatic void sin_cos(logic [31:0] ph, output longint c, output longint s);
		logic [31:0] sum;
		logic [1:0] q;
		longint z, x, y, nx;
		sum = ph + 32'h2000_0000;
		q = sum[31:30];
		z = longint'($signed(ph - {q, 30'd0}));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_TURN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_TURN[i];
			end
			x = nx;
		end
		x = clamp_q30(x);
		y = clamp_q30(y);
		case (q)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void limit_norm(inout longint vx, inout longint vy);
		bit nx, ny;
		longint unsigned a, b, m, sum, n;
		int k;
		nx = vx < 0;
		ny = vy < 0;
		a = nx ? -vx : vx;
		b = ny ? -vy : vy;
		m = m_max;
		k = 0;
		while ((a >> k) >= 64'h8000_0000 || (b >> k) >= 64'h8000_0000)
			k++;
		a >>= k;
		b >>= k;
		sum = a * a + b * b;
		if (k == 0 && sum <= m * m)
			return;
		n = int_sqrt(sum);
		if (n == 0) begin
			vx = 0;
			vy = 0;
			return;
		end
		a = a * m / n;
		b = b * m / n;
		vx = nx ? -longint'(a) : longint'(a);
		vy = ny ? -longint'(b) : longint'(b);
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic vec_t field_vector(logic signed [31:0] px, logic signed [31:0] py,
			logic [31:0] t);
		longint c, s, ex, ey, dx, dy, vx, vy, rx, ry, p;
		longint unsigned tt, q;
		vec_t r;
		tt = t;
		if (m_translate) begin
			sin_cos(32'((tt << 16) / 18), c, s);
			ex = (20 * c + 8192) >>> 14;
			ey = (5 * s + 8192) >>> 14;
			m_cx = ((ex - ey) * 759250125 + (64'sd1 << 29)) >>> 30;
			m_cy = ((ex + ey) * 759250125 + (64'sd1 << 29)) >>> 30;
		end
		dx = longint'(px) - m_cx;
		dy = longint'(py) - m_cy;
		case (m_pattern)
			MODE_UNIFORM: begin vx = m_ux; vy = m_uy; end
			MODE_CENTRIPETAL: begin vx = -dx; vy = -dy; end
			MODE_SWIRL: begin vx = -dx + dy; vy = -dx - dy; end
			MODE_SWIRL_Y: begin vx = dy; vy = -dx + dy; end
			MODE_SWIRL_X: begin vx = -dx; vy = -dx - dy; end
			MODE_HYPERBOLIC: begin vx = dx; vy = dx - dy; end
			default: begin vx = 0; vy = 0; end
		endcase
		if (m_rotate) begin
			p = m_rate * longint'(tt);
			if (p >= 0)
				q = longint'(p) / 360;
			else
				q = 64'd0 - ((longint'(-p) + 359) / 360);
			sin_cos(q[31:0], c, s);
			rx = (vx * c - vy * s + (64'sd1 << 29)) >>> 30;
			ry = (vx * s + vy * c + (64'sd1 << 29)) >>> 30;
			vx = rx;
			vy = ry;
		end
		if (m_pattern != MODE_UNIFORM)
			limit_norm(vx, vy);
		r.vx = 32'(sat_word(vx));
		r.vy = 32'(sat_word(vy));
		return r;
	endfunction

	task automatic write_reg(cfg_index_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_PATTERN_MODE: m_pattern = value[2:0];
			CFG_TRANSLATE_EN: m_translate = value[0];
			CFG_ROTATE_EN: m_rotate = value[0];
			CFG_ROTATE_RATE: m_rate = longint'($signed(value));
			CFG_MAX_MAG: m_max = value[30:0];
			CFG_UNIFORM_X: m_ux = longint'($signed(value));
			CFG_UNIFORM_Y: m_uy = longint'($signed(value));
			default: ;
		endcase
	endtask

	task automatic setup(logic [2:0] pat, bit tr, bit ro, logic [31:0] rate,
			logic [31:0] mx, logic [31:0] ux, logic [31:0] uy);
		wait_drained();
		write_reg(CFG_PATTERN_MODE, {29'd0, pat});
		write_reg(CFG_TRANSLATE_EN, {31'd0, tr});
		write_reg(CFG_ROTATE_EN, {31'd0, ro});
		write_reg(CFG_ROTATE_RATE, rate);
		write_reg(CFG_MAX_MAG, mx);
		write_reg(CFG_UNIFORM_X, ux);
		write_reg(CFG_UNIFORM_Y, uy);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_vectors.size() != 0)
			@(negedge clk);
	endtask

	task automatic send_word(logic [31:0] px, logic [31:0] py, logic [31:0] t);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		time_s <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_vectors.push_back(field_vector(px, py, t));
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 2000) << 16;
			3: return -($urandom_range(0, 2000) << 16);
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed();
		setup(3'd0, 1'b0, 1'b0, 32'd0, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
		send_word(32'd0, 32'd0, 32'd0);
		setup(3'd0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_word(32'd0, 32'd0, 32'h0001_0000);
		send_word(32'd0, 32'd0, 32'hFFFF_FFFF);
		for (int m = 1; m < 8; m++) begin
			setup(m[2:0], 1'b1, 1'b0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
			send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0002_0000);
			send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		end
		setup(3'd2, 1'b0, 1'b1, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
		send_word(32'h0010_0000, 32'hFFF0_0000, 32'h0003_0000);
		send_word(32'd0, 32'd0, 32'h0003_0000);
		setup(3'd1, 1'b0, 1'b0, 32'd0, 32'h0001_0000, 32'd0, 32'd0);
		send_word(32'h0005_0000, 32'h0005_0000, 32'd0);
		send_word(32'd1, 32'd0, 32'd0);
	endtask

	task automatic test_random(int words);
		int left;
		left = words;
		while (left > 0) begin
			setup(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? rand_word() : ($urandom_range(0, 720) - 360) << 16,
				($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 100) << 16,
				rand_word(), rand_word());
			for (int i = 0; i < 60 && left > 0; i++, left--)
				send_word(rand_word(), rand_word(), rand_word());
		end
	endtask

	task automatic test_backpressure();
		setup(3'd2, 1'b1, 1'b1, 32'h002D_0000, 32'h0040_0000, 32'd0, 32'd0);
		hold_receiver = 1'b1;
		for (int i = 0; i < 150; i++)
			send_word($urandom(), $urandom(), $urandom());
		wait_drained();
	endtask

	task automatic test_no_idle();
		idle_on = 1'b0;
		setup(3'd5, 1'b1, 1'b1, 32'hFFE0_0000, 32'h7FFF_FFFF, 32'd0, 32'd0);
		for (int i = 0; i < 200; i++)
			send_word(rand_word(), rand_word(), rand_word());
	endtask

	always begin
		@(negedge clk);
		if (hold_receiver) begin
			out_stall <= 1'b1;
			repeat (300) @(negedge clk);
			out_stall <= 1'b0;
			hold_receiver = 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		vec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vectors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: vel_x %h vel_y %h", vel_x, vel_y);
			end else begin
				want = pending_vectors.pop_front();
				if (want.vx !== vel_x || want.vy !== vel_y) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected (%h, %h) got (%h, %h)",
							want.vx, want.vy, vel_x, vel_y);
				end
			end
		end
	end

	initial begin
		m_pattern = MODE_UNIFORM;
		m_translate = 1'b0;
		m_rotate = 1'b0;
		m_rate = 0;
		m_max = 64'h7FFF_FFFF;
		m_ux = 0;
		m_uy = 0;
		m_cx = 0;
		m_cy = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1250);
		test_backpressure();
		test_no_idle();
		wait_drained();
		repeat (LATENCY + 20) @(negedge clk);
		if (mismatches == 0 && pending_vectors.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb NOT OK");
		$finish;
	end
endmodule
